FILE: rtl/btpc_pkg.sv
// Package with shared constants and types for the barometric compensation block.
`default_nettype none
package btpc_pkg;
  localparam int unsigned WordW = 32;
  localparam logic [1:0] RegCalA = 2'd0;
  localparam logic [1:0] RegCalB = 2'd1;
  localparam logic [1:0] RegCalC = 2'd2;
  localparam logic [31:0] PressOffset = 32'd4000;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] SignBit = 32'h8000_0000;
  localparam logic [31:0] HalfRange = 32'd32768;
  localparam logic [31:0] CorrA = 32'd3038;
  localparam logic [31:0] CorrB = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] CorrC = 32'd3791;
  typedef logic [WordW-1:0] word_t;
endpackage
`default_nettype wire

FILE: rtl/baro_temp_pressure_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// One item is taken at a time. A sequencer drives one shared 32x32 multiplier and one
// shared radix-2 divider that resolves one quotient bit per cycle. A temperature item
// passes 3 setup steps, 32 divider steps, the final step and the output load; out_tvalid
// rises and the block is ready again in the same cycle. A pressure item passes 9
// preparation steps, 32 divider steps, 4 correction steps and the output load. A zero
// divisor skips the division, and for pressure also the correction steps. The result
// moves to an output register and the block returns to idle at once. A finished result
// that finds the previous one still not taken waits until that one has left, which
// adds the stall to the item.
`default_nettype none
module baro_temp_pressure_compensation (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [63:0] cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // raw_value[15:0]
  input  wire         in_tuser,   // mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // value[31:0]
  output logic [1:0]  out_tuser   // div_error, kind
);
  localparam logic [4:0] S_IDLE = 5'd0, S_T0 = 5'd1, S_T1 = 5'd2, S_T2 = 5'd3,
    S_TDIV = 5'd4, S_TEND = 5'd5, S_P0 = 5'd6, S_P1 = 5'd7, S_P2 = 5'd8, S_P3 = 5'd9,
    S_P4 = 5'd10, S_P5 = 5'd11, S_P6 = 5'd12, S_P7 = 5'd13, S_P8 = 5'd14, S_PDIV = 5'd15,
    S_P9 = 5'd16, S_P10 = 5'd17, S_P11 = 5'd18, S_P12 = 5'd19, S_OUT = 5'd20;

  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  btpc_pkg::word_t b5_r, t0_r, t1_r, t2_r, t3_r, b6_r, sq_r, mres_r;
  logic [15:0] raw_r;
  logic mode_r, err_r;
  logic [4:0] st_r;
  logic [5:0] cnt_r;
  // divider state
  btpc_pkg::word_t dq_r, drem_r, dd_r;
  logic dneg_r;

  function automatic btpc_pkg::word_t sx(input logic [15:0] v);
    sx = {{16{v[15]}}, v};
  endfunction
  function automatic btpc_pkg::word_t asr(input btpc_pkg::word_t v, input int s);
    asr = btpc_pkg::word_t'($signed(v) >>> s);
  endfunction

  btpc_pkg::word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx(cal_a_r[63:48]);
  assign ac2 = sx(cal_a_r[47:32]);
  assign ac3 = sx(cal_a_r[31:16]);
  assign ac4 = {16'd0, cal_a_r[15:0]};
  assign ac5 = {16'd0, cal_b_r[63:48]};
  assign ac6 = {16'd0, cal_b_r[47:32]};
  assign b1 = sx(cal_b_r[31:16]);
  assign b2 = sx(cal_b_r[15:0]);
  assign mc = sx(cal_c_r[31:16]);
  assign md = sx(cal_c_r[15:0]);

  // Temperature divisor X1 + MD.
  btpc_pkg::word_t tden;
  assign tden = t0_r + md;

  // Shared multiplier operands chosen by state; the product is registered.
  btpc_pkg::word_t ma, mb, rawx;
  assign rawx = {16'd0, raw_r};
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_T0: begin ma = rawx - ac6; mb = ac5; end
      S_P0: begin ma = b6_r; mb = b6_r; end
      S_P1: begin ma = b2; mb = sq_r; end
      S_P2: begin ma = ac2; mb = b6_r; end
      S_P3: begin ma = ac3; mb = b6_r; end
      S_P4: begin ma = b1; mb = sq_r; end
      S_P6: begin ma = ac4; mb = t3_r + btpc_pkg::HalfRange; end
      S_P7: begin ma = rawx - t2_r; mb = btpc_pkg::PressScale; end
      S_P10: begin ma = asr(dq_r, 8); mb = asr(dq_r, 8); end
      S_P11: begin ma = mres_r; mb = btpc_pkg::CorrA; end
      S_P12: begin ma = btpc_pkg::CorrB; mb = dq_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  btpc_pkg::word_t prod;
  assign prod = ma * mb;

  // Divider step: restoring, one quotient bit per cycle.
  logic [33:0] dtrial;
  btpc_pkg::word_t dshift;
  assign dshift = {drem_r[30:0], dq_r[31]};
  assign dtrial = {1'b0, drem_r, dq_r[31]} - {2'b00, dd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0; cal_b_r <= '0; cal_c_r <= '0; b5_r <= '0;
      st_r <= S_IDLE; out_tvalid <= 1'b0; cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          btpc_pkg::RegCalA: cal_a_r <= cfg_wdata;
          btpc_pkg::RegCalB: cal_b_r <= cfg_wdata;
          btpc_pkg::RegCalC: cal_c_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          raw_r <= in_tdata; mode_r <= in_tuser; err_r <= 1'b0;
          if (in_tuser) begin
            b6_r <= b5_r - btpc_pkg::PressOffset; st_r <= S_P0;
          end else st_r <= S_T0;
        end
        // Temperature path.
        S_T0: begin mres_r <= prod; st_r <= S_T1; end
        S_T1: begin
          t0_r <= asr(mres_r, 15); t1_r <= mc << 11; st_r <= S_T2;
        end
        S_T2: begin
          if (tden == '0) begin
            err_r <= 1'b1; dq_r <= '0; st_r <= S_TEND;
          end else begin
            // Divide magnitudes; the sign is put back afterward.
            dq_r <= t1_r[31] ? -t1_r : t1_r;
            dd_r <= tden[31] ? -tden : tden;
            dneg_r <= t1_r[31] ^ tden[31];
            drem_r <= '0; cnt_r <= 6'd32; st_r <= S_TDIV;
          end
        end
        S_TDIV, S_PDIV: begin
          if (dtrial[33]) begin drem_r <= dshift; dq_r <= {dq_r[30:0], 1'b0}; end
          else begin drem_r <= dtrial[31:0]; dq_r <= {dq_r[30:0], 1'b1}; end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) st_r <= (st_r == S_TDIV) ? S_TEND : S_P9;
        end
        S_TEND: begin
          b5_r <= t0_r + (dneg_r && !err_r ? -dq_r : dq_r);
          mres_r <= err_r ? '0 : asr(t0_r + (dneg_r ? -dq_r : dq_r) + 32'd8, 4);
          st_r <= S_OUT;
        end
        // Pressure path.
        S_P0: begin sq_r <= asr(prod, 12); st_r <= S_P1; end
        S_P1: begin t0_r <= asr(prod, 11); st_r <= S_P2; end
        S_P2: begin
          t2_r <= asr((ac1 << 2) + t0_r + asr(prod, 11) + 32'd2, 2); st_r <= S_P3;
        end
        S_P3: begin t0_r <= asr(prod, 13); st_r <= S_P4; end
        S_P4: begin t1_r <= asr(prod, 16); st_r <= S_P5; end
        S_P5: begin t3_r <= asr(t0_r + t1_r + 32'd2, 2); st_r <= S_P6; end
        S_P6: begin t1_r <= prod >> 15; st_r <= S_P7; end
        S_P7: begin t0_r <= prod; st_r <= S_P8; end
        S_P8: begin
          if (t1_r == '0) begin
            err_r <= 1'b1; mres_r <= '0; st_r <= S_OUT;
          end else begin
            // dneg_r marks the branch that doubles the quotient afterward.
            dneg_r <= (t0_r >= btpc_pkg::SignBit);
            dq_r <= (t0_r >= btpc_pkg::SignBit) ? t0_r : t0_r << 1;
            dd_r <= t1_r; drem_r <= '0; cnt_r <= 6'd32; st_r <= S_PDIV;
          end
        end
        S_P9: begin
          if (dneg_r) dq_r <= dq_r << 1;
          st_r <= S_P10;
        end
        S_P10: begin mres_r <= prod; st_r <= S_P11; end
        S_P11: begin t0_r <= asr(prod, 16); st_r <= S_P12; end
        S_P12: begin
          mres_r <= dq_r + asr(t0_r + asr(prod, 16) + btpc_pkg::CorrC, 4);
          st_r <= S_OUT;
        end
        S_OUT: if (!out_tvalid) begin
          out_tdata <= mres_r; out_tuser <= {err_r, mode_r};
          out_tvalid <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // The block takes a new transaction only while idle.
  assign in_tready = (st_r == S_IDLE);

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("took item while busy");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && !out_tvalid) |=> out_tvalid) else $error("result not shown");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tdata == '0) else $error("error value nonzero");
`endif
endmodule
`default_nettype wire
